>>> rtl/wfq_finish_tag_virtual_time_defines.svh
// Assertion macros shared by the finish-tag engine.
`ifndef WFQ_FINISH_TAG_VIRTUAL_TIME_DEFINES_SVH
`define WFQ_FINISH_TAG_VIRTUAL_TIME_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WFQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wfq_pkg.sv
// Package with widths, register indexes and control structs of the finish-tag engine.
package wfq_pkg;

  localparam int TIME_W      = 48;
  localparam int ARRIVAL_W   = 32;
  localparam int FLOW_W      = 2;
  localparam int LEN_W       = 16;
  localparam int WEIGHT_W    = 16;
  localparam int RATE_W      = 24;
  localparam int SUM_W       = 18;
  localparam int PROD_W      = 40;
  localparam int DIV_DW      = 56;
  localparam int DIV_VW      = 40;
  localparam int DEP_W       = 56;
  localparam int NUM_WEIGHTS = 4;
  localparam int NUM_FLOWS_DEF = 4;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 5;

  localparam logic [TIME_W-1:0]   MAX48      = {TIME_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd256;
  localparam logic [RATE_W-1:0]   RATE_RST   = 24'd256;

  localparam logic [2:0] REG_WEIGHT_0 = 3'd0;
  localparam logic [2:0] REG_WEIGHT_1 = 3'd1;
  localparam logic [2:0] REG_WEIGHT_2 = 3'd2;
  localparam logic [2:0] REG_WEIGHT_3 = 3'd3;
  localparam logic [2:0] REG_RATE     = 3'd4;

  typedef struct packed {
    logic load;
    logic first;
    logic clear;
    logic div_proj;
    logic proj_hold;
    logic proj_take;
    logic mul_dep;
    logic apply;
    logic fin;
    logic mul_rate;
    logic div_tag;
    logic tag_apply;
  } wfq_cmd_t;

  typedef struct packed {
    logic started;
    logic busy;
    logic s_zero;
    logic depart;
    logic div_done;
    logic div_busy;
    logic flow_ok;
    logic prod_zero;
  } wfq_sts_t;

endpackage

>>> rtl/wfq_if.sv
// Valid/ready channel interfaces for input and result words.
interface wfq_in_if import wfq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ARRIVAL_W-1:0] arrival_time;
  logic [FLOW_W-1:0]    flow_index;
  logic [LEN_W-1:0]     packet_length;
  modport source(output valid, arrival_time, flow_index, packet_length, input ready);
  modport sink(input valid, arrival_time, flow_index, packet_length, output ready);
endinterface

interface wfq_out_if import wfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] flow_index_out;
  logic [TIME_W-1:0] finish_tag;
  logic [TIME_W-1:0] round_now;
  logic              tag_saturated;
  modport source(output valid, flow_index_out, finish_tag, round_now, tag_saturated,
                 input ready);
  modport sink(input valid, flow_index_out, finish_tag, round_now, tag_saturated,
               output ready);
endinterface

>>> rtl/wfq_finish_tag_virtual_time.sv
// Top level of the weighted fair queuing finish-tag engine.
// One word at a time: a new word is accepted only after the previous result is issued.
// The round projection is a pass of the shared divider (56 quotient bits) and is run
// again after each departing flow; the first word and an idle restart skip it. A result
// that waits for the sink holds the next word in the tag stage. Synchronous active-low
// reset clears the round, the time reference and all flows, and sets the weights and
// the rate to 256.
`include "wfq_finish_tag_virtual_time_defines.svh"
module wfq_finish_tag_virtual_time import wfq_pkg::*; #(
  parameter int NUM_FLOWS = NUM_FLOWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wfq_in_if.sink            in_if,
  wfq_out_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  wfq_cmd_t cmd;
  wfq_sts_t sts;

  assign cfg_pready = 1'b1;

  wfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wfq_dp #(.NUM_FLOWS(NUM_FLOWS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .arrival_time   (in_if.arrival_time),
    .flow_index     (in_if.flow_index),
    .packet_length  (in_if.packet_length),
    .cmd            (cmd),
    .sts            (sts),
    .flow_index_out (out_if.flow_index_out),
    .finish_tag     (out_if.finish_tag),
    .round_now      (out_if.round_now),
    .tag_saturated  (out_if.tag_saturated)
  );

  `WFQ_ASSERT_NEXT(a_busy_after_in, in_if.valid && in_if.ready, !in_if.ready, "input while busy")
  `WFQ_ASSERT_SAME(a_div_not_idle, sts.div_busy, !in_if.ready, "divider running while idle")
  `WFQ_ASSERT_SAME(a_out_from_work, $rose(out_if.valid), !$past(in_if.ready), "result without work")

endmodule

>>> rtl/wfq_div.sv
// Restoring divider, one quotient bit per cycle.
module wfq_div import wfq_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int VW = DIV_VW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic [VW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        quo_r <= {quo_r[DW-2:0], ge};
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/wfq_ctrl.sv
// Controller state machine sequencing round update, departures and tagging.
module wfq_ctrl import wfq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  wfq_sts_t sts,
  output wfq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PROJ, S_DIVP, S_DEP, S_APPLY, S_TAGM, S_TAGD, S_DIVT, S_TAGA
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.started) begin
          cmd.first = 1'b1;
          state_nxt = S_TAGM;
        end else if (!sts.busy) begin
          cmd.clear = 1'b1;
          state_nxt = S_TAGM;
        end else begin
          state_nxt = S_PROJ;
        end
      end
      S_PROJ: begin
        if (sts.s_zero) begin
          cmd.proj_hold = 1'b1;
          state_nxt     = S_DEP;
        end else begin
          cmd.div_proj = 1'b1;
          state_nxt    = S_DIVP;
        end
      end
      S_DIVP: begin
        if (sts.div_done) begin
          cmd.proj_take = 1'b1;
          state_nxt     = S_DEP;
        end
      end
      S_DEP: begin
        if (sts.depart) begin
          cmd.mul_dep = 1'b1;
          state_nxt   = S_APPLY;
        end else begin
          cmd.fin   = 1'b1;
          state_nxt = S_TAGM;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_PROJ;
      end
      S_TAGM: begin
        cmd.mul_rate = 1'b1;
        state_nxt    = S_TAGD;
      end
      S_TAGD: begin
        if (sts.flow_ok && !sts.prod_zero) begin
          cmd.div_tag = 1'b1;
          state_nxt   = S_DIVT;
        end else begin
          state_nxt = S_TAGA;
        end
      end
      S_DIVT: begin
        if (sts.div_done) begin
          state_nxt = S_TAGA;
        end
      end
      S_TAGA: begin
        if (!out_valid_r || out_ready) begin
          cmd.tag_apply = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/wfq_dp.sv
// Datapath: configuration registers, flow state, multipliers, divider and result word.
module wfq_dp import wfq_pkg::*; #(
  parameter int NUM_FLOWS = NUM_FLOWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [APB_AW-1:0]    cfg_paddr,
  input  logic [APB_DW-1:0]    cfg_pwdata,
  output logic [APB_DW-1:0]    cfg_prdata,
  input  logic [ARRIVAL_W-1:0] arrival_time,
  input  logic [FLOW_W-1:0]    flow_index,
  input  logic [LEN_W-1:0]     packet_length,
  input  wfq_cmd_t             cmd,
  output wfq_sts_t             sts,
  output logic [FLOW_W-1:0]    flow_index_out,
  output logic [TIME_W-1:0]    finish_tag,
  output logic [TIME_W-1:0]    round_now,
  output logic                 tag_saturated
);

  localparam int FW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;

  logic [WEIGHT_W-1:0]  weight_r [NUM_WEIGHTS];
  logic [RATE_W-1:0]    rate_r;
  logic [TIME_W-1:0]    now_r;
  logic [FLOW_W-1:0]    flow_r;
  logic [LEN_W-1:0]     len_r;
  logic [TIME_W-1:0]    round_r;
  logic [TIME_W-1:0]    last_r;
  logic                 started_r;
  logic [TIME_W-1:0]    fin_r [NUM_FLOWS];
  logic [NUM_FLOWS-1:0] val_r;
  logic [TIME_W-1:0]    proj_r;
  logic [DEP_W-1:0]     dep_r;
  logic [PROD_W-1:0]    rprod_r;
  logic [FLOW_W-1:0]    flow_out_r;
  logic [TIME_W-1:0]    tag_out_r;
  logic [TIME_W-1:0]    round_out_r;
  logic                 sat_out_r;

  logic [2:0]           reg_idx;
  logic                 cfg_wr;
  logic [SUM_W-1:0]     wsum;
  logic [TIME_W-1:0]    elapsed;
  logic                 any_valid;
  logic                 busy_any;
  logic [TIME_W-1:0]    fmin;
  logic [FW-1:0]        kmin;
  logic [TIME_W-1:0]    diff;
  logic [TIME_W+SUM_W-1:0] dep_full;
  logic [TIME_W:0]      last_sum;
  logic [DIV_DW:0]      proj_sum;
  logic [FW-1:0]        fi;
  logic                 flow_ok;
  logic [TIME_W-1:0]    base;
  logic [TIME_W:0]      tag_sum;
  logic [TIME_W-1:0]    tag_val;
  logic                 tag_sat;
  logic                 div_start;
  logic [DIV_DW-1:0]    div_dividend;
  logic [DIV_VW-1:0]    div_divisor;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_DW-1:0]    div_quo;

  assign reg_idx = cfg_paddr[4:2];
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_WEIGHT_0: cfg_prdata = APB_DW'(weight_r[0]);
      REG_WEIGHT_1: cfg_prdata = APB_DW'(weight_r[1]);
      REG_WEIGHT_2: cfg_prdata = APB_DW'(weight_r[2]);
      REG_WEIGHT_3: cfg_prdata = APB_DW'(weight_r[3]);
      REG_RATE:     cfg_prdata = APB_DW'(rate_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_comb begin
    wsum      = '0;
    any_valid = 1'b0;
    busy_any  = 1'b0;
    fmin      = '0;
    kmin      = '0;
    for (int i = 0; i < NUM_FLOWS; i++) begin
      if (val_r[i]) begin
        wsum = wsum + SUM_W'(weight_r[i]);
        if (fin_r[i] > round_r) busy_any = 1'b1;
        if (!any_valid || fin_r[i] < fmin) begin
          fmin = fin_r[i];
          kmin = FW'(i);
        end
        any_valid = 1'b1;
      end
    end
  end

  assign elapsed  = (now_r > last_r) ? now_r - last_r : '0;
  assign diff     = (fmin > round_r) ? fmin - round_r : '0;
  assign dep_full = diff * wsum;
  assign last_sum = {1'b0, last_r} + {1'b0, dep_r[TIME_W-1:0]};
  assign proj_sum = {{(DIV_DW - TIME_W + 1){1'b0}}, round_r} + {1'b0, div_quo};

  assign fi      = flow_r[FW-1:0];
  assign flow_ok = 32'(flow_r) < NUM_FLOWS;
  assign base    = (flow_ok && val_r[fi] && fin_r[fi] > round_r) ? fin_r[fi] : round_r;
  assign tag_sum = {1'b0, base} + {1'b0, div_quo[TIME_W-1:0]};

  always_comb begin
    tag_val = '0;
    tag_sat = 1'b0;
    if (flow_ok) begin
      if (rprod_r == '0) begin
        tag_val = MAX48;
        tag_sat = 1'b1;
      end else if (tag_sum[TIME_W]) begin
        tag_val = MAX48;
        tag_sat = 1'b1;
      end else begin
        tag_val = tag_sum[TIME_W-1:0];
      end
    end
  end

  assign div_start    = cmd.div_proj || cmd.div_tag;
  assign div_dividend = cmd.div_tag ? DIV_DW'({len_r, 32'b0}) : {elapsed, 8'b0};
  assign div_divisor  = cmd.div_tag ? rprod_r : DIV_VW'(wsum);

  wfq_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) weight_r[i] <= WEIGHT_RST;
      rate_r    <= RATE_RST;
      round_r   <= '0;
      last_r    <= '0;
      started_r <= 1'b0;
      val_r     <= '0;
      for (int i = 0; i < NUM_FLOWS; i++) fin_r[i] <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_WEIGHT_0: weight_r[0] <= cfg_pwdata[WEIGHT_W-1:0];
          REG_WEIGHT_1: weight_r[1] <= cfg_pwdata[WEIGHT_W-1:0];
          REG_WEIGHT_2: weight_r[2] <= cfg_pwdata[WEIGHT_W-1:0];
          REG_WEIGHT_3: weight_r[3] <= cfg_pwdata[WEIGHT_W-1:0];
          REG_RATE:     rate_r      <= cfg_pwdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.first) begin
        round_r   <= '0;
        last_r    <= now_r;
        started_r <= 1'b1;
      end
      if (cmd.clear) begin
        round_r <= '0;
        last_r  <= now_r;
        val_r   <= '0;
        for (int i = 0; i < NUM_FLOWS; i++) fin_r[i] <= '0;
      end
      if (cmd.apply) begin
        last_r      <= (last_sum[TIME_W] || dep_r[DEP_W-1:TIME_W] != '0) ?
                       MAX48 : last_sum[TIME_W-1:0];
        round_r     <= (fmin > round_r) ? fmin : round_r;
        val_r[kmin] <= 1'b0;
      end
      if (cmd.fin) begin
        round_r <= proj_r;
        last_r  <= (now_r > last_r) ? now_r : last_r;
      end
      if (cmd.tag_apply && flow_ok) begin
        fin_r[fi] <= tag_val;
        val_r[fi] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= {arrival_time, 16'b0};
      flow_r <= flow_index;
      len_r  <= packet_length;
    end
    if (cmd.proj_hold) proj_r <= round_r;
    if (cmd.proj_take) begin
      proj_r <= (proj_sum[DIV_DW:TIME_W] != '0) ? MAX48 : proj_sum[TIME_W-1:0];
    end
    if (cmd.mul_dep) dep_r <= dep_full[63:8];
    if (cmd.mul_rate) rprod_r <= rate_r * weight_r[flow_r];
    if (cmd.tag_apply) begin
      flow_out_r  <= flow_r;
      tag_out_r   <= tag_val;
      round_out_r <= round_r;
      sat_out_r   <= tag_sat;
    end
  end

  always_comb begin
    sts           = '0;
    sts.started   = started_r;
    sts.busy      = busy_any;
    sts.s_zero    = wsum == '0;
    sts.depart    = any_valid && (fmin < proj_r);
    sts.div_done  = div_done;
    sts.div_busy  = div_busy;
    sts.flow_ok   = flow_ok;
    sts.prod_zero = rprod_r == '0;
  end

  assign flow_index_out = flow_out_r;
  assign finish_tag     = tag_out_r;
  assign round_now      = round_out_r;
  assign tag_saturated  = sat_out_r;

endmodule

>>> dv/wfq_tag_checker.sv
// Checker that mirrors the finish-tag engine, predicts each result word and compares it.
`timescale 1ns / 1ps
module wfq_tag_checker import wfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wfq_in_if                 in_if,
  wfq_out_if                out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output int                mismatches,
  output int                tags_pending,
  output int                tags_seen,
  output int                tags_clipped,
  output int                departures,
  output int                idle_resets
);
  localparam logic [63:0] TOP48 = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [FLOW_W-1:0] flow;
    logic [TIME_W-1:0] tag;
    logic [TIME_W-1:0] rnd;
    logic              sat;
  } tag_word_t;

  tag_word_t   tag_queue[$];
  logic [63:0] weight[NUM_WEIGHTS];
  logic [63:0] rate;
  logic [63:0] vround;
  logic [63:0] ref_time;
  logic        running;
  logic [63:0] flow_tag[NUM_WEIGHTS];
  logic        flow_live[NUM_WEIGHTS];

  function automatic logic [63:0] live_weight();
    logic [63:0] s;
    s = 0;
    for (int i = 0; i < NUM_WEIGHTS; i++) if (flow_live[i]) s += weight[i];
    return s;
  endfunction

  function automatic logic [63:0] round_at(logic [63:0] now);
    logic [63:0] s, e, p;
    s = live_weight();
    if (s == 0) return vround;
    e = (now > ref_time) ? now - ref_time : 64'd0;
    p = vround + ((e << 8) / s);
    return (p > TOP48) ? TOP48 : p;
  endfunction

  function automatic void move_round(logic [63:0] now);
    logic        busy;
    logic [63:0] s, proj, fmin, diff, t;
    int          k;
    busy = 1'b0;
    if (!running) begin
      vround = 0;
      ref_time = now;
      running = 1'b1;
      return;
    end
    for (int i = 0; i < NUM_WEIGHTS; i++) if (flow_live[i] && flow_tag[i] > vround) busy = 1'b1;
    if (!busy) begin
      idle_resets++;
      vround = 0;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        flow_live[i] = 1'b0;
        flow_tag[i] = 0;
      end
      ref_time = now;
      return;
    end
    for (int it = 0; it <= NUM_WEIGHTS; it++) begin
      s = live_weight();
      proj = round_at(now);
      fmin = 0;
      k = -1;
      for (int i = 0; i < NUM_WEIGHTS; i++)
        if (flow_live[i] && (k < 0 || flow_tag[i] < fmin)) begin
          k = i;
          fmin = flow_tag[i];
        end
      if (k < 0 || fmin >= proj) break;
      diff = (fmin > vround) ? fmin - vround : 64'd0;
      t = ref_time + ((diff * s) >> 8);
      ref_time = (t > TOP48) ? TOP48 : t;
      if (fmin > vround) vround = fmin;
      flow_live[k] = 1'b0;
      departures++;
    end
    vround = round_at(now);
    if (now > ref_time) ref_time = now;
  endfunction

  function automatic tag_word_t tag_packet(logic [ARRIVAL_W-1:0] arr, logic [FLOW_W-1:0] flow,
                                           logic [LEN_W-1:0] len);
    tag_word_t   w;
    logic [63:0] now, prod, base, tag;
    logic        sat;
    now = {16'd0, arr, 16'd0};
    move_round(now);
    prod = rate * weight[flow];
    base = vround;
    sat = 1'b0;
    if (flow_live[flow] && flow_tag[flow] > base) base = flow_tag[flow];
    if (prod == 0) begin
      tag = TOP48;
      sat = 1'b1;
    end else begin
      tag = base + (({48'd0, len} << 32) / prod);
      if (tag > TOP48) begin
        tag = TOP48;
        sat = 1'b1;
      end
    end
    flow_tag[flow] = tag;
    flow_live[flow] = 1'b1;
    w.flow = flow;
    w.tag = tag[TIME_W-1:0];
    w.rnd = vround[TIME_W-1:0];
    w.sat = sat;
    return w;
  endfunction

  always @(posedge clk) begin
    tag_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight[i] = WEIGHT_RST;
        flow_tag[i] = 0;
        flow_live[i] = 1'b0;
      end
      rate = RATE_RST;
      vround = 0;
      ref_time = 0;
      running = 1'b0;
      tag_queue.delete();
      tags_pending = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_WEIGHT_0: weight[0] = cfg_pwdata[WEIGHT_W-1:0];
          REG_WEIGHT_1: weight[1] = cfg_pwdata[WEIGHT_W-1:0];
          REG_WEIGHT_2: weight[2] = cfg_pwdata[WEIGHT_W-1:0];
          REG_WEIGHT_3: weight[3] = cfg_pwdata[WEIGHT_W-1:0];
          REG_RATE:     rate = cfg_pwdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        e = tag_packet(in_if.arrival_time, in_if.flow_index, in_if.packet_length);
        if (e.sat) tags_clipped++;
        tag_queue = {tag_queue, e};
      end
      if (out_if.valid && out_if.ready) begin
        tags_seen++;
        if (tag_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word flow %0d tag %h", $time,
                   out_if.flow_index_out, out_if.finish_tag);
        end else begin
          e = tag_queue.pop_front();
          if (out_if.flow_index_out !== e.flow || out_if.finish_tag !== e.tag ||
              out_if.round_now !== e.rnd || out_if.tag_saturated !== e.sat) begin
            mismatches++;
            $display("%0t: expected flow %0d tag %h round %h sat %b", $time,
                     e.flow, e.tag, e.rnd, e.sat);
            $display("%0t: actual   flow %0d tag %h round %h sat %b", $time,
                     out_if.flow_index_out, out_if.finish_tag, out_if.round_now,
                     out_if.tag_saturated);
          end
        end
      end
      tags_pending = tag_queue.size();
    end
  end

  initial begin
    mismatches = 0;
    tags_pending = 0;
    tags_seen = 0;
    tags_clipped = 0;
    departures = 0;
    idle_resets = 0;
  end
endmodule

>>> dv/tb.sv
// Testbench top: drives packets, weight and rate settings, and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import wfq_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                mismatches, tags_pending, tags_seen, tags_clipped;
  int                departures, idle_resets;
  int                cycles;
  logic              hold_req;
  logic [31:0]       clock_now;

  wfq_in_if  in_if();
  wfq_out_if out_if();

  wfq_finish_tag_virtual_time dut (
    .clk, .rst_n, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  wfq_tag_checker chk (
    .clk, .rst_n, .in_if, .out_if, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready,
    .cfg_paddr, .cfg_pwdata, .mismatches, .tags_pending, .tags_seen, .tags_clipped,
    .departures, .idle_resets
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles.", cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // The receiver stalls in patterns that it picks anew at random.
  initial begin
    int mode, left, hold;
    bit fired;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    fired = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_req) fired = 1'b0;
      if (hold_req && !fired) begin
        hold = 3000;
        fired = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 600);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= $urandom_range(0, 1);
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_rates(int w0, int w1, int w2, int w3, int r);
    write_reg(REG_WEIGHT_0, w0);
    write_reg(REG_WEIGHT_1, w1);
    write_reg(REG_WEIGHT_2, w2);
    write_reg(REG_WEIGHT_3, w3);
    write_reg(REG_RATE, r);
  endtask

  // Valid stays high when the next word follows at once.
  task automatic send_packet(logic [31:0] arr, logic [1:0] flow, logic [15:0] len,
                             bit keep_valid);
    in_if.valid <= 1'b1;
    in_if.arrival_time <= arr;
    in_if.flow_index <= flow;
    in_if.packet_length <= len;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    if (!keep_valid) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    in_if.valid <= 1'b0;
    while (tags_pending != 0) @(negedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic random_traffic(int count);
    int burst, gap;
    logic [15:0] len;
    logic [31:0] step;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
        if (gap > 0) begin
          @(posedge clk);
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                        : 16'($urandom_range(1, 2000));
      case ($urandom_range(0, 19))
        0:       step = $urandom;
        1:       step = -32'($urandom_range(1, 500));
        2, 3:    step = 0;
        4:       step = $urandom_range(20000, 200000);
        default: step = $urandom_range(0, 3000);
      endcase
      clock_now += step;
      send_packet(clock_now, 2'($urandom_range(0, 3)), len, burst != 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    hold_req = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_if.valid = 1'b0;
    in_if.arrival_time = '0;
    in_if.flow_index = '0;
    in_if.packet_length = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets on reset settings: first packet, all flows, length extremes,
    // time going backwards, an idle restart and the largest arrival time.
    send_packet(32'd0, 2'd0, 16'd1, 1'b1);
    send_packet(32'd0, 2'd1, 16'hFFFF, 1'b1);
    send_packet(32'd10, 2'd2, 16'd100, 1'b1);
    send_packet(32'd20, 2'd3, 16'd300, 1'b0);
    send_packet(32'd5, 2'd0, 16'd50, 1'b0);
    send_packet(32'd70000, 2'd1, 16'd7, 1'b0);
    send_packet(32'd2000000, 2'd2, 16'd1, 1'b1);
    send_packet(32'hFFFF_FFFF, 2'd3, 16'hFFFF, 1'b0);
    drain();

    // Smallest weights and rate push tags into saturation.
    set_rates(1, 1, 1, 1, 1);
    send_packet(32'd100, 2'd0, 16'hFFFF, 1'b1);
    send_packet(32'd100, 2'd0, 16'hFFFF, 1'b1);
    send_packet(32'd101, 2'd1, 16'd1, 1'b0);
    drain();

    // Zero weight and zero rate both clip the tag.
    set_rates(0, 256, 65535, 512, 256);
    send_packet(32'd200, 2'd0, 16'd10, 1'b1);
    send_packet(32'd201, 2'd1, 16'd10, 1'b0);
    drain();
    write_reg(REG_RATE, 0);
    send_packet(32'd300, 2'd2, 16'd10, 1'b0);
    drain();

    // Largest weights and rate.
    set_rates(65535, 65535, 65535, 65535, 24'hFF_FFFF);
    clock_now = 32'd1000;
    random_traffic(150);
    drain();

    set_rates(WEIGHT_RST, WEIGHT_RST, WEIGHT_RST, WEIGHT_RST, RATE_RST);
    clock_now = 32'd0;
    random_traffic(300);
    // The receiver holds off while packets keep coming.
    hold_req <= 1'b1;
    random_traffic(40);
    hold_req <= 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_rates($urandom_range(1, 1024), $urandom_range(1, 65535), $urandom_range(1, 512),
                $urandom_range(64, 2048), $urandom_range(1, 4096));
      random_traffic(190);
      drain();
    end

    $display("Tagged %0d packets over several weight and rate settings:", tags_seen);
    $display("%0d departures, %0d idle restarts, %0d clipped tags.",
             departures, idle_resets, tags_clipped);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
